@@ design/tlpt_pkg.sv @@
// Shared types and constants for the two-level page table mapper.
// No dependencies; every design file but tlpt_ram imports this package.
package tlpt_pkg;

  localparam int ADDR_W     = 32;
  localparam int DESC_W     = 32;
  localparam int L1_DEPTH   = 4096;
  localparam int L1_IDX_W   = 12;
  localparam int L2_DEPTH   = 256;
  localparam int L2_IDX_W   = 8;
  localparam int KB_W       = 22;   // table address in 1 KB units
  localparam int FLAGS_W    = 12;
  localparam int PAGE_W     = ADDR_W - FLAGS_W;
  localparam int TU_W       = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // descriptor type field, bits 1:0
  localparam logic [1:0] FAULT_TYPE  = 2'b00;
  localparam logic [1:0] COARSE_TYPE = 2'b01;

  typedef enum logic {
    REQ_CLEAR = 1'b0,
    REQ_MAP   = 1'b1
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POOL_EMPTY = 2'd1,
    STAT_MAPPED     = 2'd2,
    STAT_SKIPPED    = 2'd3
  } status_t;

  typedef enum logic {
    REG_PAGE_FLAGS = 1'b0,
    REG_POOL_BASE  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_L1RD,
    S_ALLOC,
    S_L2RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] page_flags;
    logic [KB_W-1:0]    pool_base_kb;
  } cfg_t;

endpackage

@@ design/tlpt_if.sv @@
// Request and response channel interfaces (valid/ready) for the mapper.
// Depends on tlpt_pkg for field widths and the status type.
interface tlpt_req_if;
  import tlpt_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] vaddr;
  logic [ADDR_W-1:0] frame_addr;
  logic              first_of_region;

  modport source (output valid, req_type, vaddr, frame_addr, first_of_region,
                  input ready);
  modport sink   (input valid, req_type, vaddr, frame_addr, first_of_region,
                  output ready);
endinterface

interface tlpt_rsp_if;
  import tlpt_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [DESC_W-1:0] first_level_desc;
  logic [DESC_W-1:0] second_level_desc;
  logic [TU_W-1:0]   tables_used;

  modport source (output valid, status, first_level_desc, second_level_desc, tables_used,
                  input ready);
  modport sink   (input valid, status, first_level_desc, second_level_desc, tables_used,
                  output ready);
endinterface

@@ design/tlpt_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/tlpt_cfg_regs.sv @@
// APB-style configuration registers: page flags and pool base.
// Depends on tlpt_pkg (cfg_t, register index codes).
module tlpt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlpt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tlpt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlpt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output tlpt_pkg::cfg_t                  cfg
);
  import tlpt_pkg::*;

  reg_idx_t idx;

  // word index; byte-lane bits are ignored
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PAGE_FLAGS: cfg.page_flags   <= pwdata[FLAGS_W-1:0];
        REG_POOL_BASE:  cfg.pool_base_kb <= pwdata[KB_W-1:0];
        default:        cfg              <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAGE_FLAGS: prdata = CFG_DATA_W'(cfg.page_flags);
      REG_POOL_BASE:  prdata = CFG_DATA_W'(cfg.pool_base_kb);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ design/two_level_page_table_mapper.sv @@
// Two-level page table mapper: maps one 4 KB page per request word.
// A request goes through a first-level read and, if the entry exists, a pool read;
// a skipped page goes straight to the result, a refused descriptor or an empty pool
// ends after the first-level read, and a newly taken second-level table is zeroed.
// A clear zeroes both tables. One request in flight at a time.
// Reset starts the same zeroing pass over both tables; no request is taken meanwhile.
module two_level_page_table_mapper #(
  parameter int POOL_TABLES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  tlpt_req_if.sink                        req,
  tlpt_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlpt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tlpt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlpt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tlpt_pkg::*;

  localparam int TW         = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int NFW        = $clog2(POOL_TABLES + 1);
  localparam int POOL_DEPTH = POOL_TABLES * L2_DEPTH;
  localparam int PAW        = $clog2(POOL_DEPTH);
  localparam int CW         = (PAW > L1_IDX_W) ? PAW : L1_IDX_W;
  localparam int SWEEP_LEN  = (POOL_DEPTH > L1_DEPTH) ? POOL_DEPTH : L1_DEPTH;
  localparam logic [NFW-1:0]  NF_LIMIT   = NFW'(POOL_TABLES);
  localparam logic [KB_W-1:0] TBL_LIMIT  = KB_W'(POOL_TABLES);
  localparam logic [CW:0]     L1_SPAN    = (CW+1)'(L1_DEPTH);
  localparam logic [CW:0]     POOL_SPAN  = (CW+1)'(POOL_DEPTH);
  localparam logic [CW-1:0]   SWEEP_LAST = CW'(SWEEP_LEN - 1);

  cfg_t cfg;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  tlpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // state: control registers
  // ---------------------------------------------------------------------------
  state_t               state, state_next;
  logic [CW-1:0]        cnt, cnt_next;          // sweep counter (clear, L2 zeroing)
  logic                 clr_reply, clr_reply_next; // sweep was a clear request
  logic [NFW-1:0]       next_free, next_free_next;
  logic                 region_failed, region_failed_next;
  logic                 out_valid, out_valid_next;

  // per-request payload registers
  logic [L1_IDX_W-1:0]  l1i, l1i_next;
  logic [L2_IDX_W-1:0]  l2i, l2i_next;
  logic [PAGE_W-1:0]    pa_page, pa_page_next;
  logic [DESC_W-1:0]    desc, desc_next;
  logic [TW-1:0]        tbl, tbl_next;
  status_t              res_status, res_status_next;
  logic [DESC_W-1:0]    res_l1d, res_l1d_next;
  logic [DESC_W-1:0]    res_l2d, res_l2d_next;

  // output register
  status_t              out_status, out_status_next;
  logic [DESC_W-1:0]    out_l1d, out_l1d_next;
  logic [DESC_W-1:0]    out_l2d, out_l2d_next;
  logic [TU_W-1:0]      out_used, out_used_next;

  // memories
  logic                 l1_we;
  logic [L1_IDX_W-1:0]  l1_addr;
  logic [DESC_W-1:0]    l1_wdata, l1_rdata;
  logic                 pool_we;
  logic [PAW-1:0]       pool_addr;
  logic [DESC_W-1:0]    pool_wdata, pool_rdata;

  // datapath helpers
  logic [KB_W-1:0]      delta;      // table index decoded from an existing descriptor
  logic [KB_W-1:0]      new_kb;     // address of a freshly taken table
  logic [DESC_W-1:0]    entry;      // second-level page descriptor to write
  logic                 skip;

  tlpt_ram #(.WIDTH(DESC_W), .DEPTH(L1_DEPTH)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .addr  (l1_addr),
    .wdata (l1_wdata),
    .rdata (l1_rdata)
  );

  tlpt_ram #(.WIDTH(DESC_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  assign delta  = l1_rdata[DESC_W-1 -: KB_W] - cfg.pool_base_kb;
  assign new_kb = cfg.pool_base_kb + KB_W'(next_free);
  assign entry  = {pa_page, cfg.page_flags};
  assign skip   = region_failed && !req.first_of_region;

  assign req.ready             = (state == S_IDLE);
  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.first_level_desc  = out_l1d;
  assign rsp.second_level_desc = out_l2d;
  assign rsp.tables_used       = out_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      clr_reply     <= 1'b0;
      next_free     <= '0;
      region_failed <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      clr_reply     <= clr_reply_next;
      next_free     <= next_free_next;
      region_failed <= region_failed_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    l1i        <= l1i_next;
    l2i        <= l2i_next;
    pa_page    <= pa_page_next;
    desc       <= desc_next;
    tbl        <= tbl_next;
    res_status <= res_status_next;
    res_l1d    <= res_l1d_next;
    res_l2d    <= res_l2d_next;
    out_status <= out_status_next;
    out_l1d    <= out_l1d_next;
    out_l2d    <= out_l2d_next;
    out_used   <= out_used_next;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  //   S_CLEAR : zero both tables, one entry of each a cycle
  //   S_IDLE  : take a request, issue first-level read
  //   S_L1RD  : descriptor back; allocate, refuse, or issue pool read
  //   S_ALLOC : zero the new table; the requested entry gets the page instead
  //   S_L2RD  : pool entry back; write page if the slot is free
  //   S_DONE  : hand the result to the output register
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    clr_reply_next     = clr_reply;
    next_free_next     = next_free;
    region_failed_next = region_failed;
    out_valid_next     = out_valid && !rsp.ready;
    l1i_next           = l1i;
    l2i_next           = l2i;
    pa_page_next       = pa_page;
    desc_next          = desc;
    tbl_next           = tbl;
    res_status_next    = res_status;
    res_l1d_next       = res_l1d;
    res_l2d_next       = res_l2d;
    out_status_next    = out_status;
    out_l1d_next       = out_l1d;
    out_l2d_next       = out_l2d;
    out_used_next      = out_used;

    l1_we      = 1'b0;
    l1_addr    = l1i;
    l1_wdata   = '0;
    pool_we    = 1'b0;
    pool_addr  = PAW'({tbl, l2i});
    pool_wdata = '0;

    unique case (state)
      S_CLEAR: begin
        // pool is swept too: a stale descriptor can land on a table that
        // has not been taken since the clear
        l1_we     = ({1'b0, cnt} < L1_SPAN);
        l1_addr   = cnt[L1_IDX_W-1:0];
        pool_we   = ({1'b0, cnt} < POOL_SPAN);
        pool_addr = cnt[PAW-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == SWEEP_LAST) begin
          cnt_next = '0;
          if (clr_reply) begin
            res_status_next = STAT_OK;
            res_l1d_next    = '0;
            res_l2d_next    = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        l1_addr = req.vaddr[ADDR_W-1 -: L1_IDX_W];
        if (req.valid) begin
          l1i_next     = req.vaddr[ADDR_W-1 -: L1_IDX_W];
          l2i_next     = req.vaddr[ADDR_W-L1_IDX_W-1 -: L2_IDX_W];
          pa_page_next = req.frame_addr[ADDR_W-1 -: PAGE_W];
          if (req.req_type == REQ_CLEAR) begin
            next_free_next     = '0;
            region_failed_next = 1'b0;
            clr_reply_next     = 1'b1;
            cnt_next           = '0;
            state_next         = S_CLEAR;
          end else begin
            region_failed_next = skip;
            if (skip) begin
              res_status_next = STAT_SKIPPED;
              res_l1d_next    = '0;
              res_l2d_next    = '0;
              state_next      = S_DONE;
            end else begin
              state_next = S_L1RD;
            end
          end
        end
      end

      S_L1RD: begin
        if (l1_rdata[1:0] == FAULT_TYPE) begin
          if (next_free >= NF_LIMIT) begin
            res_status_next    = STAT_POOL_EMPTY;
            res_l1d_next       = '0;
            res_l2d_next       = '0;
            region_failed_next = 1'b1;
            state_next         = S_DONE;
          end else begin
            desc_next      = {new_kb, {(DESC_W - KB_W - 2){1'b0}}, COARSE_TYPE};
            l1_we          = 1'b1;
            l1_wdata       = {new_kb, {(DESC_W - KB_W - 2){1'b0}}, COARSE_TYPE};
            tbl_next       = TW'(next_free);
            next_free_next = next_free + 1'b1;
            cnt_next       = '0;
            state_next     = S_ALLOC;
          end
        end else begin
          desc_next = l1_rdata;
          if (delta >= TBL_LIMIT) begin
            // stale descriptor: points outside the current pool
            res_status_next    = STAT_MAPPED;
            res_l1d_next       = l1_rdata;
            res_l2d_next       = '0;
            region_failed_next = 1'b1;
            state_next         = S_DONE;
          end else begin
            tbl_next   = TW'(delta);
            pool_addr  = PAW'({TW'(delta), l2i});
            state_next = S_L2RD;
          end
        end
      end

      S_ALLOC: begin
        pool_we    = 1'b1;
        pool_addr  = PAW'({tbl, cnt[L2_IDX_W-1:0]});
        pool_wdata = (cnt[L2_IDX_W-1:0] == l2i) ? entry : '0;
        cnt_next   = cnt + 1'b1;
        if (cnt[L2_IDX_W-1:0] == '1) begin
          cnt_next        = '0;
          res_status_next = STAT_OK;
          res_l1d_next    = desc;
          res_l2d_next    = entry;
          state_next      = S_DONE;
        end
      end

      S_L2RD: begin
        res_l1d_next = desc;
        if (pool_rdata != '0) begin
          res_status_next    = STAT_MAPPED;
          res_l2d_next       = '0;
          region_failed_next = 1'b1;
        end else begin
          pool_we         = 1'b1;
          pool_wdata      = entry;
          res_status_next = STAT_OK;
          res_l2d_next    = entry;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_l1d_next    = res_l1d;
          out_l2d_next    = res_l2d;
          out_used_next   = TU_W'(next_free);
          clr_reply_next  = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for two_level_page_table_mapper: directed and random map/clear words.
// Depends on tlpt_pkg, the tlpt_req_if / tlpt_rsp_if interfaces and the mapper RTL.
`timescale 1ns / 100ps

import tlpt_pkg::*;

localparam int MAP_POOL_TABLES = 16;

typedef struct {
  status_t           status;
  logic [DESC_W-1:0] l1_desc;
  logic [DESC_W-1:0] l2_desc;
  logic [TU_W-1:0]   tables_used;
} map_result_t;

// Shadow page tables plus the queue of mapping results still owed by the block.
class mapping_scoreboard;
  bit [DESC_W-1:0]  shadow_l1 [L1_DEPTH];
  bit [DESC_W-1:0]  l2_pool  [MAP_POOL_TABLES*L2_DEPTH];
  bit [FLAGS_W-1:0] flags;
  bit [KB_W-1:0]    base_kb;
  int unsigned      next_table;
  bit               region_failed;
  map_result_t      expected_mappings [$];
  int unsigned      failures;
  int unsigned      results_seen;

  function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    if (idx == REG_PAGE_FLAGS) flags = value[FLAGS_W-1:0];
    else base_kb = value[KB_W-1:0];
  endfunction

  function int unsigned pending();
    return expected_mappings.size();
  endfunction

  function map_result_t predict_mapping(req_code_t kind, logic [ADDR_W-1:0] va,
                                        logic [ADDR_W-1:0] pa, logic first);
    map_result_t       r;
    logic [DESC_W-1:0] desc;
    logic [KB_W-1:0]   kb;
    int unsigned       table_no;
    int unsigned       slot;
    bit                ok;
    r.status  = STAT_OK;
    r.l1_desc = '0;
    r.l2_desc = '0;
    if (kind == REQ_CLEAR) begin
      foreach (shadow_l1[i]) shadow_l1[i] = '0;
      foreach (l2_pool[i]) l2_pool[i] = '0;
      next_table    = 0;
      region_failed = 0;
    end else begin
      if (first) region_failed = 0;
      if (region_failed) begin
        r.status = STAT_SKIPPED;
      end else begin
        desc     = shadow_l1[va[31:20]];
        table_no = 0;
        ok       = 1;
        if (desc[1:0] == FAULT_TYPE) begin
          if (next_table >= MAP_POOL_TABLES) begin
            r.status = STAT_POOL_EMPTY;
            ok = 0;
          end else begin
            table_no = next_table;
            next_table++;
            for (int i = 0; i < L2_DEPTH; i++) l2_pool[table_no*L2_DEPTH + i] = '0;
            kb   = base_kb + KB_W'(table_no);
            desc = {kb, 8'h00, COARSE_TYPE};
            shadow_l1[va[31:20]] = desc;
          end
        end else begin
          // descriptor address relative to the current pool base, mod 2^22 KB
          kb = desc[31:10] - base_kb;
          if (kb >= MAP_POOL_TABLES) begin
            r.l1_desc = desc;
            r.status  = STAT_MAPPED;
            ok = 0;
          end else begin
            table_no = 32'(kb);
          end
        end
        if (ok) begin
          r.l1_desc = desc;
          slot = table_no*L2_DEPTH + va[19:12];
          if (l2_pool[slot] != '0) begin
            r.status = STAT_MAPPED;
            ok = 0;
          end else begin
            l2_pool[slot] = {pa[31:12], flags};
            r.l2_desc = l2_pool[slot];
          end
        end
        if (!ok) region_failed = 1;
      end
    end
    r.tables_used = next_table[TU_W-1:0];
    return r;
  endfunction

  function void note_request(req_code_t kind, logic [ADDR_W-1:0] va,
                             logic [ADDR_W-1:0] pa, logic first);
    expected_mappings.push_back(predict_mapping(kind, va, pa, first));
  endfunction

  function void check_result(status_t st, logic [DESC_W-1:0] l1d, logic [DESC_W-1:0] l2d,
                             logic [TU_W-1:0] tu);
    map_result_t want;
    if (expected_mappings.size() == 0) begin
      $display("%0t: result word with nothing expected, status %0d", $time, st);
      failures++;
      return;
    end
    want = expected_mappings.pop_front();
    results_seen++;
    if (st !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      failures++;
    end
    if (l1d !== want.l1_desc) begin
      $display("%0t: first_level_desc expected %h actual %h", $time, want.l1_desc, l1d);
      failures++;
    end
    if (l2d !== want.l2_desc) begin
      $display("%0t: second_level_desc expected %h actual %h", $time, want.l2_desc, l2d);
      failures++;
    end
    if (tu !== want.tables_used) begin
      $display("%0t: tables_used expected %0d actual %0d", $time, want.tables_used, tu);
      failures++;
    end
  endfunction
endclass

module tb_top;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // percent of cycles in which each side idles; zeroed for random requests 150 to 259
  int unsigned idle_pct = 19;

  mapping_scoreboard board = new;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_mapper #(
    .POOL_TABLES(MAP_POOL_TABLES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Monitor: every handshake seen at the rising edge. Request words feed the
  // predictor, response words get checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      board.note_request(req_code_t'(req_ch.req_type), req_ch.vaddr,
                         req_ch.frame_addr, req_ch.first_of_region);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.status, rsp_ch.first_level_desc,
                         rsp_ch.second_level_desc, rsp_ch.tables_used);
  end

  // Response sink: random backpressure, plus one long hold-off so the
  // request side fills up and stalls.
  initial begin : result_sink
    bit held;
    held = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && board.results_seen >= 120) begin
        held = 1;
        rsp_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      rsp_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // APB write: setup cycle, access cycle, register written when pready is seen.
  // Entered and left at a falling edge.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offer one request word with random idle cycles ahead of it; returns at
  // the falling edge after acceptance with valid still high.
  task automatic send_request(input req_code_t kind, input logic [ADDR_W-1:0] va,
                              input logic [ADDR_W-1:0] pa, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid           = 1'b1;
    req_ch.req_type        = kind;
    req_ch.vaddr           = va;
    req_ch.frame_addr      = pa;
    req_ch.first_of_region = first;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the block settle
  // back to idle before touching registers.
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       n;
    int unsigned       phase_len;
    int unsigned       set_size;
    int unsigned       region_len;
    logic [11:0]       l1_set [20];
    logic [7:0]        l2_pick;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    logic [KB_W-1:0]   base_now;
    bit                shifted;

    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_CLEAR;
    req_ch.vaddr           = '0;
    req_ch.frame_addr      = '0;
    req_ch.first_of_region = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    // all flags set, pool base at the top so table 1 wraps to address 0
    write_reg(REG_PAGE_FLAGS, 32'h0000_0FFF);
    write_reg(REG_POOL_BASE, 32'h003F_FFFF);
    send_request(REQ_MAP, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1);  // new table
    send_request(REQ_MAP, 32'hFFFF_F000, 32'h0000_0000, 1'b1);  // already mapped
    send_request(REQ_MAP, 32'hFFFF_E000, 32'h1234_5000, 1'b0);  // skipped
    send_request(REQ_MAP, 32'hFFFF_E000, 32'h1234_5000, 1'b1);  // new region, same table
    send_request(REQ_MAP, 32'h0000_0FFF, 32'h0000_0000, 1'b1);  // wrapped table address
    send_request(REQ_MAP, 32'h0000_1000, 32'h8000_0FFF, 1'b0);

    // move the pool far away: the old first-level descriptors go stale
    wait_idle();
    write_reg(REG_POOL_BASE, 32'd1000);
    write_reg(REG_PAGE_FLAGS, 32'h0000_0000);
    send_request(REQ_MAP, 32'hFFFF_F000, 32'h0000_1000, 1'b1);  // stale descriptor
    send_request(REQ_MAP, 32'h0000_0000, 32'h0000_1000, 1'b0);  // skipped
    // page 0 with no flags writes a zero entry, so it still looks free
    send_request(REQ_MAP, 32'h0010_0000, 32'h0000_0000, 1'b1);
    send_request(REQ_MAP, 32'h0010_0000, 32'hABCD_E000, 1'b1);
    // use up the rest of the pool, then one more
    for (int i = 3; i < MAP_POOL_TABLES; i++)
      send_request(REQ_MAP, {12'(i), 20'($urandom)}, $urandom, 1'b1);
    send_request(REQ_MAP, 32'h7FF0_0000, 32'h5555_5000, 1'b1);  // pool exhausted
    send_request(REQ_CLEAR, $urandom, $urandom, 1'b1);

    // ---- random part: phases of regions over a small first-level working set ----
    sent = 0;
    while (sent < 450) begin
      // tables are empty here, so any pool base is safe
      wait_idle();
      case ($urandom_range(2))
        0:       write_reg(REG_PAGE_FLAGS, 32'h0000_0000);
        1:       write_reg(REG_PAGE_FLAGS, 32'h0000_0FFF);
        default: write_reg(REG_PAGE_FLAGS, 32'($urandom_range(4095)));
      endcase
      case ($urandom_range(3))
        0:       base_now = '0;
        1:       base_now = '1;
        default: base_now = KB_W'($urandom);
      endcase
      write_reg(REG_POOL_BASE, 32'(base_now));
      shifted   = 0;
      set_size  = $urandom_range(3, 20);
      foreach (l1_set[i]) l1_set[i] = 12'($urandom);
      phase_len = $urandom_range(15, 50);
      n = 0;
      while (n < phase_len) begin
        idle_pct = (sent >= 150 && sent < 260) ? 0 : 19;
        // at most one base move per phase, far enough that every older
        // descriptor decodes outside the pool
        if (!shifted && n > phase_len / 2 && $urandom_range(2) == 0) begin
          wait_idle();
          base_now = base_now + KB_W'($urandom_range(16, 4194288));
          write_reg(REG_POOL_BASE, 32'(base_now));
          write_reg(REG_PAGE_FLAGS, 32'($urandom_range(4095)));
          shifted = 1;
        end
        if ($urandom_range(9) == 0) begin
          // noise: any address, any region marker
          send_request(REQ_MAP, $urandom, $urandom, 1'($urandom_range(1)));
          n++;
          sent++;
        end else begin
          region_len = $urandom_range(1, 8);
          l2_pick = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
          va = {l1_set[$urandom_range(set_size - 1)], l2_pick, 12'($urandom)};
          pa = $urandom;
          for (int k = 0; k < region_len; k++) begin
            send_request(REQ_MAP, va, pa, k == 0);
            va = va + 32'h0000_1000;
            pa = pa + 32'h0000_1000;
            n++;
            sent++;
          end
        end
      end
      send_request(REQ_CLEAR, $urandom, $urandom, 1'($urandom_range(1)));
      sent++;
    end

    // drain, then a quiet tail to catch any stray result word
    wait_idle();
    repeat (40) @(negedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tlpt_pkg.sv
design/tlpt_if.sv
design/tlpt_ram.sv
design/tlpt_cfg_regs.sv
design/two_level_page_table_mapper.sv
test/tb_top.sv
